[sv/spr_pkg.sv]
package spr_pkg;

  localparam int TW = 64;  // turn fraction width, full turn = 2^64
  localparam int RW = 34;  // Q3.30 vector carrier
  localparam int VW = 36;  // vectoring carrier, room for CORDIC gain
  localparam int QF = 30;
  localparam int PW = 2 * RW;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [TW-1:0] turn_t;
  typedef logic signed [RW-1:0] qval_t;
  typedef logic signed [VW-1:0] vval_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [PW+1:0] acc_t;

  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
  localparam turn_t HALF_TURN = 64'h8000_0000_0000_0000;
  localparam turn_t QUARTER_TURN = 64'h4000_0000_0000_0000;

  typedef enum logic [0:0] {
    CFG_CENTRE_RA  = 1'b0,
    CFG_CENTRE_DEC = 1'b1
  } cfg_reg_e;

  // Rotated vector handed from front to back.
  typedef struct packed {
    qval_t a;
    qval_t b;
    qval_t c;
    logic  last;
  } vec_item_t;

  // atan(2^-i) in turn fractions, evaluated at elaboration only.
  function automatic turn_t atan_turn(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] quo;
    logic [7:0] rem;
    logic [127:0] prod;
    int unsigned k;
    int unsigned e;
    int unsigned d;
    int j;
    if (i == 0) return 64'h2000_0000_0000_0000;
    sum = '0;
    for (k = 0; i * (2 * k + 1) < 64; k++) begin
      e = i * (2 * k + 1);
      d = 2 * k + 1;
      num = 64'd1 << (64 - e);
      rem = '0;
      quo = '0;
      for (j = 63; j >= 0; j--) begin
        rem = {rem[6:0], num[j]};
        if (rem >= 8'(d)) begin
          rem = rem - 8'(d);
          quo[j] = 1'b1;
        end
      end
      if (k[0]) sum = sum - quo;
      else sum = sum + quo;
    end
    prod = {64'd0, sum} * {64'd0, INV_TWO_PI};
    return prod[127:64];
  endfunction

  function automatic qval_t round_acc(input acc_t s);
    acc_t t;
    t = (s + (acc_t'(1) <<< (QF - 1))) >>> QF;
    return t[RW-1:0];
  endfunction

  function automatic qval_t mul_round(input qval_t a, input qval_t b);
    acc_t p;
    p = a * b;
    return round_acc(p);
  endfunction

  function automatic prod_t mul_full(input qval_t a, input qval_t b);
    prod_t p;
    p = a * b;
    return p;
  endfunction

endpackage

[sv/spherical_pole_rotation_unit.sv]
// Rotates each source position (ra, dec) so that the configured centre becomes
// the pole, returning (rotated_ra, rotated_dec) as binary angles, tlast carried
// through. One source is accepted every clock cycle when the output side keeps
// up. The datapath is a front pipeline of CORDIC_STEPS+5 stages (four sin/cos
// CORDIC lanes and the matrix multiply), a 4-entry queue, and a back pipeline
// of 2*CORDIC_STEPS+6 stages (two vectoring CORDICs in series) feeding a
// 2-entry output buffer. Front and back stall independently.
// Centre registers are written over the cfg channel (index 0 centre_ra,
// index 1 centre_dec), always ready; write them only while no source is in
// flight.
module spherical_pole_rotation_unit #(
  parameter int ANGLE_BITS   = 32,
  parameter int CORDIC_STEPS = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [ANGLE_BITS-1:0] source_ra, [2*ANGLE_BITS-1:ANGLE_BITS] source_dec
  input  logic [((2*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [ANGLE_BITS-1:0] rotated_ra, [2*ANGLE_BITS-1:ANGLE_BITS] rotated_dec
  output logic [((2*ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [0:0]            cfg_index_i,
  input  logic [ANGLE_BITS-1:0] cfg_data_i
);

  localparam int TDATA_W = ((2 * ANGLE_BITS + 7) / 8) * 8;

  logic signed [ANGLE_BITS-1:0] centre_ra_q, centre_dec_q;
  logic en_front;
  logic front_valid;
  spr_pkg::vec_item_t front_item, queue_item;
  logic q_full, q_valid, q_pop;
  logic signed [ANGLE_BITS-1:0] rot_ra, rot_dec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_ra_q <= '0;
      centre_dec_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (spr_pkg::cfg_reg_e'(cfg_index_i))
        spr_pkg::CFG_CENTRE_RA:  centre_ra_q <= cfg_data_i;
        spr_pkg::CFG_CENTRE_DEC: centre_dec_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en_front = !q_full;
  assign s_axis_tready = en_front;

  spr_front #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .en_i(en_front),
    .in_valid_i(s_axis_tvalid),
    .source_ra_i(s_axis_tdata[ANGLE_BITS-1:0]),
    .source_dec_i(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .last_source_i(s_axis_tlast),
    .centre_ra_i(centre_ra_q),
    .centre_dec_i(centre_dec_q),
    .out_valid_o(front_valid),
    .out_item_o(front_item)
  );

  spr_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(en_front && front_valid),
    .data_i(front_item),
    .pop_i(q_pop),
    .valid_o(q_valid),
    .full_o(q_full),
    .data_o(queue_item)
  );

  spr_back #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS)) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(q_valid),
    .in_item_i(queue_item),
    .in_pop_o(q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .rotated_ra_o(rot_ra),
    .rotated_dec_o(rot_dec),
    .last_out_o(m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'({rot_dec, rot_ra});

endmodule

[sv/spr_sincos.sv]
module spr_sincos #(
  parameter int STEPS = 30
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  spr_pkg::turn_t theta_i,
  output spr_pkg::qval_t cos_o,
  output spr_pkg::qval_t sin_o
);

  spr_pkg::qval_t x_q [STEPS+1];
  spr_pkg::qval_t y_q [STEPS+1];
  spr_pkg::turn_t th_q [STEPS+1];
  logic flip_q [STEPS+1];
  spr_pkg::qval_t cos_q, sin_q;
  spr_pkg::turn_t th_sum;
  logic flip;

  // back half-turn: rotate by half a turn, negate at the end
  assign th_sum = theta_i + spr_pkg::QUARTER_TURN;
  assign flip = th_sum[spr_pkg::TW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= spr_pkg::qval_t'(spr_pkg::INV_GAIN);
      y_q[0] <= '0;
      th_q[0] <= flip ? (theta_i ^ spr_pkg::HALF_TURN) : theta_i;
      flip_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam spr_pkg::turn_t ATAN = spr_pkg::atan_turn(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!th_q[i][spr_pkg::TW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          th_q[i+1] <= th_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          th_q[i+1] <= th_q[i] + ATAN;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= flip_q[STEPS] ? -x_q[STEPS] : x_q[STEPS];
      sin_q <= flip_q[STEPS] ? -y_q[STEPS] : y_q[STEPS];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[sv/spr_vector.sv]
module spr_vector #(
  parameter int STEPS  = 30,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  spr_pkg::qval_t    a_i,
  input  spr_pkg::qval_t    b_i,
  input  logic [SIDE_W-1:0] side_i,
  output spr_pkg::turn_t    ang_o,
  output spr_pkg::qval_t    mag_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int MW = spr_pkg::VW + 32;

  spr_pkg::vval_t a_q [STEPS+1];
  spr_pkg::vval_t b_q [STEPS+1];
  spr_pkg::turn_t z_q [STEPS+1];
  logic zero_q [STEPS+1];
  logic [SIDE_W-1:0] side_q [STEPS+1];

  spr_pkg::turn_t ang1_q, ang2_q;
  logic signed [MW-1:0] mprod_q;
  logic [SIDE_W-1:0] side1_q, side2_q;
  spr_pkg::qval_t mag_q;

  spr_pkg::vval_t a_ext, b_ext;
  logic signed [MW-1:0] mprod;
  logic signed [MW-1:0] mround;

  assign a_ext = spr_pkg::vval_t'(a_i);
  assign b_ext = spr_pkg::vval_t'(b_i);

  // left half-plane: negate both and start at half a turn
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (a_i == '0) && (b_i == '0);
      if (a_i < 0) begin
        a_q[0] <= -a_ext;
        b_q[0] <= -b_ext;
        z_q[0] <= spr_pkg::HALF_TURN;
      end else begin
        a_q[0] <= a_ext;
        b_q[0] <= b_ext;
        z_q[0] <= '0;
      end
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam spr_pkg::turn_t ATAN = spr_pkg::atan_turn(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!b_q[i][spr_pkg::VW-1]) begin
          a_q[i+1] <= a_q[i] + (b_q[i] >>> i);
          b_q[i+1] <= b_q[i] - (a_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end else begin
          a_q[i+1] <= a_q[i] - (b_q[i] >>> i);
          b_q[i+1] <= b_q[i] + (a_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    mprod = a_q[STEPS] * spr_pkg::INV_GAIN;
    mround = (mprod_q + (MW'(1) <<< (spr_pkg::QF - 1))) >>> spr_pkg::QF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang1_q <= zero_q[STEPS] ? '0 : z_q[STEPS];
      mprod_q <= mprod;
      side1_q <= side_q[STEPS];
      ang2_q <= ang1_q;
      mag_q <= mround[spr_pkg::RW-1:0];
      side2_q <= side1_q;
    end
  end

  assign ang_o = ang2_q;
  assign mag_o = mag_q;
  assign side_o = side2_q;

endmodule

[sv/spr_front.sv]
module spr_front #(
  parameter int ANGLE_BITS = 32,
  parameter int STEPS      = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic signed [ANGLE_BITS-1:0] source_ra_i,
  input  logic signed [ANGLE_BITS-1:0] source_dec_i,
  input  logic                         last_source_i,
  input  logic signed [ANGLE_BITS-1:0] centre_ra_i,
  input  logic signed [ANGLE_BITS-1:0] centre_dec_i,
  output logic                         out_valid_o,
  output spr_pkg::vec_item_t           out_item_o
);

  localparam int SHIFT = spr_pkg::TW - ANGLE_BITS;
  localparam int LAT = STEPS + 5;

  spr_pkg::turn_t th_ra, th_dec, th_cra, th_cdec;
  spr_pkg::qval_t cr, sr, cd, sd, ca, sa, cdd, sdd;

  logic [LAT-1:0] vld_q;
  logic [LAT-1:0] last_q;

  spr_pkg::qval_t x_q, y_q, z_q, m11_q, m13_q, m21_q, m23_q;
  spr_pkg::qval_t sa1_q, ca1_q, sd1_q, cd1_q;
  spr_pkg::prod_t p_ax_q, p_ay_q, p_az_q, p_bx_q, p_by_q, p_bz_q, p_cz_q, p_cx_q;
  spr_pkg::qval_t a_q, b_q, c_q;
  spr_pkg::acc_t sum_a, sum_b, sum_c;

  assign th_ra = spr_pkg::turn_t'(source_ra_i) << SHIFT;
  assign th_dec = spr_pkg::turn_t'(source_dec_i) << SHIFT;
  assign th_cra = spr_pkg::turn_t'(centre_ra_i) << SHIFT;
  assign th_cdec = spr_pkg::turn_t'(centre_dec_i) << SHIFT;

  spr_sincos #(.STEPS(STEPS)) u_src_ra (
    .clk_i(clk_i), .en_i(en_i), .theta_i(th_ra), .cos_o(cr), .sin_o(sr));
  spr_sincos #(.STEPS(STEPS)) u_src_dec (
    .clk_i(clk_i), .en_i(en_i), .theta_i(th_dec), .cos_o(cd), .sin_o(sd));
  spr_sincos #(.STEPS(STEPS)) u_cen_ra (
    .clk_i(clk_i), .en_i(en_i), .theta_i(th_cra), .cos_o(ca), .sin_o(sa));
  spr_sincos #(.STEPS(STEPS)) u_cen_dec (
    .clk_i(clk_i), .en_i(en_i), .theta_i(th_cdec), .cos_o(cdd), .sin_o(sdd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q <= {last_q[LAT-2:0], last_source_i};
    end
  end

  // direction cosines and matrix terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= spr_pkg::mul_round(cd, cr);
      y_q <= spr_pkg::mul_round(cd, sr);
      z_q <= sd;
      m11_q <= spr_pkg::mul_round(ca, sdd);
      m13_q <= spr_pkg::mul_round(ca, cdd);
      m21_q <= spr_pkg::mul_round(sa, sdd);
      m23_q <= spr_pkg::mul_round(sa, cdd);
      sa1_q <= sa;
      ca1_q <= ca;
      sd1_q <= sdd;
      cd1_q <= cdd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ax_q <= spr_pkg::mul_full(m11_q, x_q);
      p_ay_q <= spr_pkg::mul_full(sa1_q, y_q);
      p_az_q <= spr_pkg::mul_full(m13_q, z_q);
      p_bx_q <= spr_pkg::mul_full(m21_q, x_q);
      p_by_q <= spr_pkg::mul_full(ca1_q, y_q);
      p_bz_q <= spr_pkg::mul_full(m23_q, z_q);
      p_cz_q <= spr_pkg::mul_full(sd1_q, z_q);
      p_cx_q <= spr_pkg::mul_full(cd1_q, x_q);
    end
  end

  always_comb begin
    sum_a = spr_pkg::acc_t'(p_ax_q) - spr_pkg::acc_t'(p_ay_q) + spr_pkg::acc_t'(p_az_q);
    sum_b = spr_pkg::acc_t'(p_bx_q) + spr_pkg::acc_t'(p_by_q) + spr_pkg::acc_t'(p_bz_q);
    sum_c = spr_pkg::acc_t'(p_cz_q) - spr_pkg::acc_t'(p_cx_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= spr_pkg::round_acc(sum_a);
      b_q <= spr_pkg::round_acc(sum_b);
      c_q <= spr_pkg::round_acc(sum_c);
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_item_o = '{a: a_q, b: b_q, c: c_q, last: last_q[LAT-1]};

endmodule

[sv/spr_queue.sv]
module spr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  spr_pkg::vec_item_t data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output logic               full_o,
  output spr_pkg::vec_item_t data_o
);

  localparam int AW = $clog2(spr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(spr_pkg::QUEUE_DEPTH + 1);

  spr_pkg::vec_item_t mem_q [spr_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign full_o = (cnt_q == CW'(spr_pkg::QUEUE_DEPTH));
  assign data_o = mem_q[rd_q];

endmodule

[sv/spr_back.sv]
module spr_back #(
  parameter int ANGLE_BITS = 32,
  parameter int STEPS      = 30
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  spr_pkg::vec_item_t           in_item_i,
  output logic                         in_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ANGLE_BITS-1:0] rotated_ra_o,
  output logic signed [ANGLE_BITS-1:0] rotated_dec_o,
  output logic                         last_out_o
);

  localparam int SHIFT = spr_pkg::TW - ANGLE_BITS;
  localparam int LAT = 2 * STEPS + 6;
  localparam int S1_W = spr_pkg::RW + 1;
  localparam int S2_W = spr_pkg::TW + 1;
  localparam int OB_W = 2 * ANGLE_BITS + 1;

  logic en;
  logic [LAT-1:0] vld_q;

  spr_pkg::turn_t ang1, ang2, ang1_d2;
  spr_pkg::qval_t mag1, c1;
  logic [S1_W-1:0] side1;
  logic [S2_W-1:0] side2;
  logic last1, last2;
  spr_pkg::turn_t ra_rnd, dec_rnd;

  logic [OB_W-1:0] ob_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign en = (cnt_q != 2'd2);
  assign in_pop_o = en && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  spr_vector #(.STEPS(STEPS), .SIDE_W(S1_W)) u_vec_ra (
    .clk_i(clk_i), .en_i(en), .a_i(in_item_i.a), .b_i(in_item_i.b),
    .side_i({in_item_i.c, in_item_i.last}),
    .ang_o(ang1), .mag_o(mag1), .side_o(side1));

  assign c1 = side1[S1_W-1:1];
  assign last1 = side1[0];

  // only the angle of the second vectoring pass is needed
  spr_vector #(.STEPS(STEPS), .SIDE_W(S2_W)) u_vec_dec (
    .clk_i(clk_i), .en_i(en), .a_i(mag1), .b_i(c1), .side_i({ang1, last1}),
    .ang_o(ang2), .mag_o(), .side_o(side2));

  assign ang1_d2 = side2[S2_W-1:1];
  assign last2 = side2[0];

  // round to nearest output LSB, wrapping
  assign ra_rnd = ang1_d2 + (spr_pkg::turn_t'(1) << (SHIFT - 1));
  assign dec_rnd = ang2 + (spr_pkg::turn_t'(1) << (SHIFT - 1));

  assign push = en && vld_q[LAT-1];
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ob_q[wr_q] <= {last2, dec_rnd[spr_pkg::TW-1:SHIFT], ra_rnd[spr_pkg::TW-1:SHIFT]};
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign rotated_ra_o = ob_q[rd_q][ANGLE_BITS-1:0];
  assign rotated_dec_o = ob_q[rd_q][2*ANGLE_BITS-1:ANGLE_BITS];
  assign last_out_o = ob_q[rd_q][OB_W-1];

endmodule
